// ----- rtl/sma_pkg.sv -----
// Shared types and codes for the stack machine ALU.
// No dependencies; imported by every module of the block.
package sma_pkg;

    // per-cycle command to a chain of stack cells
    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP
    } stk_cmd_t;

    // request to the iterative multiply/divide unit
    typedef struct packed {
        logic start;
        logic div;
    } md_req_t;

    // operation codes
    localparam logic [4:0] OP_LIT     = 5'd0;
    localparam logic [4:0] OP_DROP    = 5'd1;
    localparam logic [4:0] OP_DUP     = 5'd2;
    localparam logic [4:0] OP_SWAP    = 5'd3;
    localparam logic [4:0] OP_OVER    = 5'd4;
    localparam logic [4:0] OP_QDUP    = 5'd5;
    localparam logic [4:0] OP_AND     = 5'd6;
    localparam logic [4:0] OP_OR      = 5'd7;
    localparam logic [4:0] OP_XOR     = 5'd8;
    localparam logic [4:0] OP_INVERT  = 5'd9;
    localparam logic [4:0] OP_SHIFT   = 5'd10;
    localparam logic [4:0] OP_ADD     = 5'd11;
    localparam logic [4:0] OP_SUB     = 5'd12;
    localparam logic [4:0] OP_NEGATE  = 5'd13;
    localparam logic [4:0] OP_DIVMOD  = 5'd14;
    localparam logic [4:0] OP_DIV     = 5'd15;
    localparam logic [4:0] OP_MOD     = 5'd16;
    localparam logic [4:0] OP_MUL     = 5'd17;
    localparam logic [4:0] OP_ABS     = 5'd18;
    localparam logic [4:0] OP_MAX     = 5'd19;
    localparam logic [4:0] OP_MIN     = 5'd20;
    localparam logic [4:0] OP_EQUAL   = 5'd21;
    localparam logic [4:0] OP_LESS    = 5'd22;
    localparam logic [4:0] OP_GREATER = 5'd23;
    localparam logic [4:0] OP_CLEAR   = 5'd24;
    localparam logic [4:0] OP_TO_R    = 5'd25;
    localparam logic [4:0] OP_R_FROM  = 5'd26;
    localparam logic [4:0] OP_R_FETCH = 5'd27;
    localparam logic [4:0] OP_R_CLEAR = 5'd28;

    // status codes, larger wins
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_UF   = 3'd1;
    localparam logic [2:0] ST_OVF  = 3'd2;
    localparam logic [2:0] ST_DIV0 = 3'd3;
    localparam logic [2:0] ST_ROVF = 3'd4;
    localparam logic [2:0] ST_RUF  = 3'd5;

endpackage

// ----- rtl/stack_machine_alu_top.sv -----
// Top level of the stack machine ALU: sequencer, ALU and the two cell stacks.
// Depends on sma_pkg, sma_stack and sma_muldiv.
//
// channel | dir | tdata                    | tuser
// s_*     | in  | value[31:0]              | op[4:0]
// m_*     | out | top,next,ddepth,rdepth   | status[2:0]
//
// An item passes through accept, decode, one pop or one push on the data stack
// per step, a final settle step, then the result load. Multiply and divide
// with a nonzero top also run the bit-serial unit between decode and the steps.
// Reset clears both depths and all control; cell contents are not reset.
// A held result does not block the next word; the sequencer waits in its
// last cycle only while the output register is still full.
module stack_machine_alu_top
    import sma_pkg::*;
#(
    parameter int STACK_DEPTH  = 16,
    parameter int RETURN_DEPTH = 16,
    parameter int CELL_BITS    = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [4:0]  s_tuser,   // [4:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [31:0] top_value, [63:32] next_value,
                                   // [68:64] data_depth, [73:69] return_depth
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int C  = CELL_BITS;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int RW = $clog2(RETURN_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MD, S_STEP, S_FIN} state_t;

    state_t         state_reg;
    logic [4:0]     op_reg;
    logic [C-1:0]   val_reg;
    logic [DW-1:0]  dcnt_reg;
    logic [RW-1:0]  rcnt_reg;
    logic [1:0]     npop_reg;
    logic [1:0]     npush_reg;
    logic [C-1:0]   p0_reg;
    logic [C-1:0]   p1_reg;
    logic [2:0]     st_reg;
    logic           m_tvalid_reg;
    logic [31:0]    top_out_reg;
    logic [31:0]    next_out_reg;
    logic [4:0]     ddep_out_reg;
    logic [4:0]     rdep_out_reg;
    logic [2:0]     st_out_reg;

    logic [C-1:0]   d_top;
    logic [C-1:0]   d_sec;
    logic [C-1:0]   r_top;
    logic [C-1:0]   a;
    logic [C-1:0]   b;
    logic [C-1:0]   alu_res;
    logic           d_full;
    logic           r_full;
    logic           r_empty;
    stk_cmd_t       d_cmd;
    stk_cmd_t       r_cmd;
    md_req_t        md_req;
    logic           md_done;
    logic [C-1:0]   md_quo;
    logic [C-1:0]   md_rem;
    logic [C-1:0]   md_prod;
    logic [C-1:0]   fin_top;
    logic [C-1:0]   fin_sec;
    logic           out_load;

    logic [1:0]     ex_npop;
    logic [1:0]     ex_npush;
    logic [C-1:0]   ex_p0;
    logic [C-1:0]   ex_p1;
    logic [2:0]     ex_st;
    logic           ex_dclr;
    logic [RW-1:0]  ex_rcnt;

    // operands as popped from the data stack, zero when absent
    assign a       = (dcnt_reg != '0) ? d_top : '0;
    assign b       = (dcnt_reg >= DW'(2)) ? d_sec : '0;
    assign d_full  = (dcnt_reg == DW'(STACK_DEPTH));
    assign r_full  = (rcnt_reg == RW'(RETURN_DEPTH));
    assign r_empty = (rcnt_reg == '0);

    // single-result ALU
    always_comb
    begin
        case (op_reg)
            OP_AND:     alu_res = b & a;
            OP_OR:      alu_res = b | a;
            OP_XOR:     alu_res = b ^ a;
            OP_INVERT:  alu_res = ~a;
            OP_SHIFT:   alu_res = a[C-1] ? (b >> (-a)) : (b << a);
            OP_ADD:     alu_res = b + a;
            OP_SUB:     alu_res = b - a;
            OP_NEGATE:  alu_res = -a;
            OP_ABS:     alu_res = a[C-1] ? -a : a;
            OP_MAX:     alu_res = ($signed(b) < $signed(a)) ? a : b;
            OP_MIN:     alu_res = ($signed(a) < $signed(b)) ? a : b;
            OP_EQUAL:   alu_res = C'(b == a);
            OP_LESS:    alu_res = C'($signed(b) < $signed(a));
            OP_GREATER: alu_res = C'($signed(a) < $signed(b));
            default:    alu_res = '0;
        endcase
    end

    // decode: pop/push counts, push words and status for the execute cycle
    always_comb
    begin
        ex_npop  = 2'd0;
        ex_npush = 2'd0;
        ex_p0    = p0_reg;
        ex_p1    = p1_reg;
        ex_st    = ST_OK;
        ex_dclr  = 1'b0;
        ex_rcnt  = rcnt_reg;
        unique case (op_reg) inside
            OP_LIT:
            begin
                ex_p0    = val_reg;
                ex_npush = 2'd1;
            end
            OP_DROP:
            begin
                ex_npop = 2'd1;
                if (dcnt_reg == '0) ex_st = ST_UF;
            end
            OP_DUP:
            begin
                ex_p0    = a;
                ex_npush = 2'd1;
                if (dcnt_reg == '0) ex_st = ST_UF;
            end
            OP_SWAP, OP_OVER:
            begin
                ex_p0    = a;
                ex_p1    = b;
                ex_npop  = (op_reg == OP_SWAP) ? 2'd2 : 2'd1;
                ex_npush = 2'd2;
                if (dcnt_reg < DW'(2)) ex_st = ST_UF;
            end
            OP_QDUP:
            begin
                ex_p0 = a;
                if (dcnt_reg == '0) ex_st = ST_UF;
                else if (a != '0) ex_npush = 2'd1;
            end
            OP_INVERT, OP_NEGATE, OP_ABS:
            begin
                ex_p0    = alu_res;
                ex_npop  = 2'd1;
                ex_npush = 2'd1;
                if (dcnt_reg == '0) ex_st = ST_UF;
            end
            OP_DIVMOD, OP_DIV, OP_MOD, OP_MUL:
            begin
                ex_p0    = '0;
                ex_p1    = '0;
                ex_npop  = 2'd2;
                ex_npush = (op_reg == OP_DIVMOD) ? 2'd2 : 2'd1;
                if (a == '0 && op_reg != OP_MUL) ex_st = ST_DIV0;
                else if (dcnt_reg < DW'(2)) ex_st = ST_UF;
            end
            OP_CLEAR:
            begin
                ex_dclr = 1'b1;
            end
            OP_TO_R:
            begin
                if (r_full)
                begin
                    ex_dclr = 1'b1;
                    ex_rcnt = '0;
                    ex_st   = ST_ROVF;
                end
                else
                begin
                    ex_npop = 2'd1;
                    ex_rcnt = rcnt_reg + RW'(1);
                    if (dcnt_reg == '0) ex_st = ST_UF;
                end
            end
            OP_R_FROM:
            begin
                if (r_empty)
                begin
                    ex_dclr = 1'b1;
                    ex_rcnt = '0;
                    ex_st   = ST_RUF;
                end
                else
                begin
                    ex_p0    = r_top;
                    ex_npush = 2'd1;
                    ex_rcnt  = rcnt_reg - RW'(1);
                end
            end
            OP_R_FETCH:
            begin
                ex_p0    = r_empty ? '0 : r_top;
                ex_npush = 2'd1;
                if (r_empty) ex_st = ST_UF;
            end
            OP_R_CLEAR:
            begin
                ex_rcnt = '0;
            end
            OP_AND, OP_OR, OP_XOR, OP_SHIFT, OP_ADD, OP_SUB, OP_MAX,
            OP_MIN, OP_EQUAL, OP_LESS, OP_GREATER:
            begin
                ex_p0    = alu_res;
                ex_npop  = 2'd2;
                ex_npush = 2'd1;
                if (dcnt_reg < DW'(2)) ex_st = ST_UF;
            end
            default:
            begin
            end
        endcase
    end

    // stack commands
    always_comb
    begin
        d_cmd = STK_HOLD;
        r_cmd = STK_HOLD;
        if (state_reg == S_STEP)
        begin
            if (npop_reg != '0)
            begin
                if (dcnt_reg != '0)
                begin
                    d_cmd = STK_POP;
                end
            end
            else if (npush_reg != '0 && !d_full)
            begin
                d_cmd = STK_PUSH;
            end
        end
        if (state_reg == S_EXEC)
        begin
            if (op_reg == OP_TO_R && !r_full)
            begin
                r_cmd = STK_PUSH;
            end
            else if (op_reg == OP_R_FROM && !r_empty)
            begin
                r_cmd = STK_POP;
            end
        end
    end

    assign md_req.start = (state_reg == S_EXEC) && (a != '0) &&
                          (op_reg == OP_DIVMOD || op_reg == OP_DIV ||
                           op_reg == OP_MOD || op_reg == OP_MUL);
    assign md_req.div   = (op_reg != OP_MUL);

    sma_stack #(.WIDTH(C), .DEPTH(STACK_DEPTH)) u_dstack (
        .clk       (clk),
        .cmd       (d_cmd),
        .push_data (p0_reg),
        .top       (d_top),
        .second    (d_sec)
    );

    sma_stack #(.WIDTH(C), .DEPTH(RETURN_DEPTH)) u_rstack (
        .clk       (clk),
        .cmd       (r_cmd),
        .push_data (a),
        .top       (r_top),
        .second    ()
    );

    sma_muldiv #(.WIDTH(C)) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .a     (a),
        .b     (b),
        .done  (md_done),
        .quo   (md_quo),
        .rem   (md_rem),
        .prod  (md_prod)
    );

    assign fin_top  = a;
    assign fin_sec  = b;
    assign out_load = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= '0;
            val_reg      <= '0;
            dcnt_reg     <= '0;
            rcnt_reg     <= '0;
            npop_reg     <= '0;
            npush_reg    <= '0;
            p0_reg       <= '0;
            p1_reg       <= '0;
            st_reg       <= ST_OK;
            m_tvalid_reg <= 1'b0;
            top_out_reg  <= '0;
            next_out_reg <= '0;
            ddep_out_reg <= '0;
            rdep_out_reg <= '0;
            st_out_reg   <= ST_OK;
        end
        else
        begin
            m_tvalid_reg <= out_load || (m_tvalid_reg && !m_tready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= s_tuser;
                        val_reg   <= C'($signed(s_tdata));
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    npop_reg  <= ex_npop;
                    npush_reg <= ex_npush;
                    p0_reg    <= ex_p0;
                    p1_reg    <= ex_p1;
                    st_reg    <= ex_st;
                    rcnt_reg  <= ex_rcnt;
                    if (ex_dclr) dcnt_reg <= '0;
                    state_reg <= md_req.start ? S_MD : S_STEP;
                end
                S_MD:
                begin
                    if (md_done)
                    begin
                        state_reg <= S_STEP;
                        case (op_reg)
                            OP_DIVMOD:
                            begin
                                p0_reg <= md_rem;
                                p1_reg <= md_quo;
                            end
                            OP_DIV:  p0_reg <= md_quo;
                            OP_MOD:  p0_reg <= md_rem;
                            default: p0_reg <= md_prod;
                        endcase
                    end
                end
                S_STEP:
                begin
                    // one pop or one push per cycle, pops first
                    if (npop_reg != '0)
                    begin
                        npop_reg <= npop_reg - 2'd1;
                        if (dcnt_reg != '0) dcnt_reg <= dcnt_reg - DW'(1);
                    end
                    else if (npush_reg != '0)
                    begin
                        npush_reg <= npush_reg - 2'd1;
                        p0_reg    <= p1_reg;
                        if (d_full)
                        begin
                            dcnt_reg <= '0;
                            if (st_reg < ST_OVF) st_reg <= ST_OVF;
                        end
                        else
                        begin
                            dcnt_reg <= dcnt_reg + DW'(1);
                        end
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_load)
                    begin
                        top_out_reg  <= 32'($signed(fin_top));
                        next_out_reg <= 32'($signed(fin_sec));
                        ddep_out_reg <= 5'(dcnt_reg);
                        rdep_out_reg <= 5'(rcnt_reg);
                        st_out_reg   <= st_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, rdep_out_reg, ddep_out_reg, next_out_reg, top_out_reg};
    assign m_tuser  = st_out_reg;

    // checks
    a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= DW'(STACK_DEPTH))
        else $error("data depth beyond stack size");

    a_rcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= RW'(RETURN_DEPTH))
        else $error("return depth beyond stack size");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= ST_RUF))
        else $error("status code out of range");

endmodule

// ----- rtl/sma_cell.sv -----
// One stack cell: holds a single entry, shifts toward or away from the top.
// Depends on sma_pkg.
module sma_cell
    import sma_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  stk_cmd_t         cmd,
    input  logic [WIDTH-1:0] from_up,    // neighbor nearer the top
    input  logic [WIDTH-1:0] from_down,  // neighbor farther from the top
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] q_reg;

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        case (cmd)
            STK_PUSH: q_reg <= from_up;
            STK_POP:  q_reg <= from_down;
            default:  q_reg <= q_reg;
        endcase
    end

    assign q = q_reg;

endmodule

// ----- rtl/sma_stack.sv -----
// Stack built as a row of sma_cell, top entry in cell 0.
// Depends on sma_pkg and sma_cell.
module sma_stack
    import sma_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
)
(
    input  logic             clk,
    input  stk_cmd_t         cmd,
    input  logic [WIDTH-1:0] push_data,
    output logic [WIDTH-1:0] top,
    output logic [WIDTH-1:0] second
);

    logic [WIDTH-1:0] q [DEPTH];

    // each cell sees its two neighbors; the ends see the push word and itself
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WIDTH-1:0] up_w;
        logic [WIDTH-1:0] down_w;
        if (i == 0)
        begin : g_first
            assign up_w = push_data;
        end
        else
        begin : g_mid
            assign up_w = q[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign down_w = q[i];
        end
        else
        begin : g_rest
            assign down_w = q[i+1];
        end
        sma_cell #(.WIDTH(WIDTH)) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .from_up   (up_w),
            .from_down (down_w),
            .q         (q[i])
        );
    end

    assign top    = q[0];
    assign second = q[1];

endmodule

// ----- rtl/sma_muldiv.sv -----
// Iterative unsigned multiply and restoring divide, one bit per cycle.
// Depends on sma_pkg.
module sma_muldiv
    import sma_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  md_req_t          req,
    input  logic [WIDTH-1:0] a,      // multiplier / divisor
    input  logic [WIDTH-1:0] b,      // multiplicand / dividend
    output logic             done,
    output logic [WIDTH-1:0] quo,
    output logic [WIDTH-1:0] rem,
    output logic [WIDTH-1:0] prod
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    cnt_reg;
    logic             div_reg;
    logic             done_reg;
    logic [WIDTH-1:0] x_reg;  // accumulator / partial remainder
    logic [WIDTH-1:0] y_reg;  // shifted multiplicand / dividend-quotient
    logic [WIDTH-1:0] z_reg;  // multiplier / divisor
    logic [WIDTH:0]   trial;

    assign trial = {x_reg, y_reg[WIDTH-1]} - {1'b0, z_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (req.start)
            begin
                cnt_reg <= CW'(WIDTH);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_reg <= req.div;
            x_reg   <= '0;
            y_reg   <= b;
            z_reg   <= a;
        end
        else if (cnt_reg != '0)
        begin
            if (div_reg)
            begin
                x_reg <= trial[WIDTH] ? {x_reg[WIDTH-2:0], y_reg[WIDTH-1]} : trial[WIDTH-1:0];
                y_reg <= {y_reg[WIDTH-2:0], ~trial[WIDTH]};
            end
            else
            begin
                if (z_reg[0])
                begin
                    x_reg <= x_reg + y_reg;
                end
                y_reg <= {y_reg[WIDTH-2:0], 1'b0};
                z_reg <= {1'b0, z_reg[WIDTH-1:1]};
            end
        end
    end

    assign done = done_reg;
    assign quo  = y_reg;
    assign rem  = x_reg;
    assign prod = x_reg;

endmodule
